// ===== src/lrbc_pkg.sv =====
// Package for the block cache lookup: item types, tag store entry, config codes.
// Used by the channel interfaces, the compare unit and the top module.
`default_nettype none

package lrbc_pkg;

    // Field widths of the items and of the tag store.
    localparam int ADDR_W     = 31;
    localparam int STAMP_W    = 31;
    localparam int OUT_SLOT_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [ADDR_W-1:0]  ADDR_ONES = {ADDR_W{1'b1}};
    localparam logic [STAMP_W-1:0] STAMP_MAX = 31'd2147483646;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] ACTIVE_SLOTS_RST = 5'd8;
    localparam logic [CFG_DATA_W-1:0] BLOCK_LOG2_RST   = 5'd13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2   = 1'd1;

    // Operation codes of an input item.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_TOUCH  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] byte_offset;
    } t_in_item;

    typedef struct packed {
        logic                  hit;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  need_fill;
        logic [ADDR_W-1:0]     block_start;
        logic                  evicted_valid;
        logic [ADDR_W-1:0]     evicted_start;
    } t_out_item;

    // One tag store entry: block start address and use stamp.
    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Sequencer to scan unit controls.
    typedef struct packed {
        logic clear;
        logic step;
        logic slot_valid;
    } t_scan_ctl;

    // Scan unit status back to the sequencer.
    typedef struct packed {
        logic hit_found;
        logic empty_found;
    } t_scan_flags;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TREAD,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

// ===== src/lrbc_req_if.sv =====
// Input channel of the block cache lookup: valid, ready and one request item.
// Depends on lrbc_pkg for the item type.
`default_nettype none

interface lrbc_req_if
    import lrbc_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== src/lrbc_rsp_if.sv =====
// Output channel of the block cache lookup: valid, ready and one result item.
// Depends on lrbc_pkg for the item type.
`default_nettype none

interface lrbc_rsp_if
    import lrbc_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== src/lrbc_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none

module lrbc_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/lrbc_scan.sv =====
// Shared compare unit: takes one tag store entry per step and tracks the first
// matching slot, the first empty slot and the least recently used slot.
// Depends on lrbc_pkg.
`default_nettype none

module lrbc_scan
    import lrbc_pkg::*;
#(
    parameter int SLOT_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_scan_ctl         i_ctl,
    input  wire logic [SLOT_W-1:0] i_idx,
    input  wire t_entry            i_entry,
    input  wire logic [ADDR_W-1:0] i_blk,
    output t_scan_flags            o_flags,
    output logic      [SLOT_W-1:0] o_hit_idx,
    output logic      [SLOT_W-1:0] o_empty_idx,
    output logic      [SLOT_W-1:0] o_best_idx,
    output logic      [ADDR_W-1:0] o_best_start
);

    logic               r_hit_found;
    logic               r_empty_found;
    logic               r_best_set;
    logic [SLOT_W-1:0]  r_hit_idx;
    logic [SLOT_W-1:0]  r_empty_idx;
    logic [SLOT_W-1:0]  r_best_idx;
    logic [ADDR_W-1:0]  r_best_start;
    logic [STAMP_W-1:0] r_best_stamp;

    logic w_match;
    logic w_older;

    // One equality compare and one magnitude compare per step.
    assign w_match = i_ctl.slot_valid && (i_entry.start == i_blk);
    assign w_older = !r_best_set || (i_entry.stamp < r_best_stamp);

    // Found flags are cleared when a new lookup starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
            r_best_set    <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
            r_best_set    <= 1'b0;
        end else if (i_ctl.step) begin
            if (w_match) begin
                r_hit_found <= 1'b1;
            end
            if (!i_ctl.slot_valid) begin
                r_empty_found <= 1'b1;
            end
            r_best_set <= 1'b1;
        end
    end

    // Candidate indexes; the first one seen wins, ties keep the lower index.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && !i_ctl.clear) begin
            if (w_match && !r_hit_found) begin
                r_hit_idx <= i_idx;
            end
            if (!i_ctl.slot_valid && !r_empty_found) begin
                r_empty_idx <= i_idx;
            end
            if (w_older) begin
                r_best_idx   <= i_idx;
                r_best_start <= i_entry.start;
                r_best_stamp <= i_entry.stamp;
            end
        end
    end

    assign o_flags.hit_found   = r_hit_found;
    assign o_flags.empty_found = r_empty_found;
    assign o_hit_idx           = r_hit_idx;
    assign o_empty_idx         = r_empty_idx;
    assign o_best_idx          = r_best_idx;
    assign o_best_start        = r_best_start;

endmodule

`default_nettype wire

// ===== src/lru_block_cache_lookup.sv =====
// Lookup: accepted, then the compare unit steps through the active slots (ST_SCAN), then
// the result is registered in the update state (ST_UPDATE). Touch reads the current slot
// (ST_TREAD) before the update state, or goes straight to it without a current slot.
// The block takes the next item only after the update state; a result still waiting on the
// output holds the update state. Synchronous active-low reset clears valid bits, use
// counter and current slot and sets config to 8 slots, 8 KiB blocks.
`default_nettype none

module lru_block_cache_lookup
    import lrbc_pkg::*;
#(
    parameter int MAX_SLOTS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lrbc_req_if.sink                   i_req,
    lrbc_rsp_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NUM_W  = $clog2(MAX_SLOTS + 1);

    // Control state.
    t_state                r_state;
    t_state                n_state;
    logic                  r_cur_valid;
    logic [SLOT_W-1:0]     r_cur_idx;
    logic [STAMP_W-1:0]    r_use_cnt;
    logic [MAX_SLOTS-1:0]  r_valid;
    logic [CFG_DATA_W-1:0] r_active;
    logic [CFG_DATA_W-1:0] r_bsl;
    logic [NUM_W-1:0]      r_idx;
    logic                  r_out_valid;

    // Payload state.
    logic                  r_op;
    logic [ADDR_W-1:0]     r_blk;
    logic [NUM_W-1:0]      r_n;
    logic [ADDR_W-1:0]     r_tstart;
    t_out_item             r_out;

    // Combinational signals.
    logic                  w_in_ready;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_commit;
    logic [NUM_W-1:0]      w_n;
    logic [ADDR_W-1:0]     w_blk;
    logic [SLOT_W-1:0]     w_proc_idx;
    logic [SLOT_W-1:0]     w_rd_addr;
    t_entry                w_rd_entry;
    t_scan_ctl             w_scan_ctl;
    t_scan_flags           w_flags;
    logic [SLOT_W-1:0]     w_hit_idx;
    logic [SLOT_W-1:0]     w_empty_idx;
    logic [SLOT_W-1:0]     w_best_idx;
    logic [ADDR_W-1:0]     w_best_start;
    logic [SLOT_W-1:0]     w_sel;
    logic                  w_we;
    t_entry                w_wdata;
    t_out_item             w_out_item;

    // Handshake on both channels.
    assign w_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && w_in_ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_commit    = (r_state == ST_UPDATE) && w_out_free;
    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.item  = r_out;

    // Number of slots searched, with out-of-range settings clamped.
    always_comb begin
        priority if (r_active == '0) begin
            w_n = NUM_W'(1);
        end else if (32'(r_active) > 32'(MAX_SLOTS)) begin
            w_n = NUM_W'(MAX_SLOTS);
        end else begin
            w_n = NUM_W'(r_active);
        end
    end

    // Block start of the requested offset; a shift of the width or more clears it.
    assign w_blk      = i_req.item.byte_offset & (ADDR_ONES << r_bsl);
    assign w_proc_idx = SLOT_W'(r_idx - NUM_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (i_req.item.op == OP_LOOKUP) begin
                        n_state = ST_SCAN;
                    end else if (r_cur_valid) begin
                        n_state = ST_TREAD;
                    end else begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx >= r_n) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_TREAD: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: tag store read address and compare unit controls.
    always_comb begin
        w_rd_addr             = r_idx[SLOT_W-1:0];
        w_scan_ctl.clear      = 1'b0;
        w_scan_ctl.step       = 1'b0;
        w_scan_ctl.slot_valid = r_valid[w_proc_idx];
        w_we                  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_rd_addr        = (i_req.item.op == OP_LOOKUP) ? '0 : r_cur_idx;
                w_scan_ctl.clear = w_accept;
            end
            ST_SCAN: begin
                w_scan_ctl.step = 1'b1;
            end
            ST_TREAD: begin
                w_rd_addr = r_cur_idx;
            end
            ST_UPDATE: begin
                w_we = w_out_free && ((r_op == OP_LOOKUP) || r_cur_valid);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Slot choice and result item.
    always_comb begin
        w_out_item = '0;
        w_sel      = r_cur_idx;
        if (r_op == OP_LOOKUP) begin
            priority if (w_flags.hit_found) begin
                w_sel = w_hit_idx;
            end else if (w_flags.empty_found) begin
                w_sel = w_empty_idx;
            end else begin
                w_sel                    = w_best_idx;
                w_out_item.evicted_valid = 1'b1;
                w_out_item.evicted_start = w_best_start;
            end
            w_out_item.hit         = w_flags.hit_found;
            w_out_item.need_fill   = !w_flags.hit_found;
            w_out_item.slot        = OUT_SLOT_W'(w_sel);
            w_out_item.block_start = r_blk;
        end else if (r_cur_valid) begin
            w_out_item.hit         = 1'b1;
            w_out_item.slot        = OUT_SLOT_W'(r_cur_idx);
            w_out_item.block_start = r_tstart;
        end
        w_wdata.start = (r_op == OP_LOOKUP) ? r_blk : r_tstart;
        w_wdata.stamp = r_use_cnt;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_valid <= 1'b0;
            r_cur_idx   <= '0;
            r_use_cnt   <= '0;
            r_valid     <= '0;
            r_active    <= ACTIVE_SLOTS_RST;
            r_bsl       <= BLOCK_LOG2_RST;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_SLOTS: r_active <= i_cfg_data;
                    CFG_BLOCK_LOG2:   r_bsl    <= i_cfg_data;
                    default:          r_active <= r_active;
                endcase
            end
            if (w_accept) begin
                r_idx <= NUM_W'(1);
            end else if ((r_state == ST_SCAN) && (r_idx < r_n)) begin
                r_idx <= r_idx + NUM_W'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
                if (r_op == OP_LOOKUP) begin
                    r_valid[w_sel] <= 1'b1;
                    r_cur_valid    <= 1'b1;
                    r_cur_idx      <= w_sel;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            // Stamp refresh advances the use counter, which saturates.
            if (w_we && (r_use_cnt < STAMP_MAX)) begin
                r_use_cnt <= r_use_cnt + STAMP_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.item.op;
            r_blk <= w_blk;
            r_n   <= w_n;
        end
        if (r_state == ST_TREAD) begin
            r_tstart <= w_rd_entry.start;
        end
        if (w_commit) begin
            r_out <= w_out_item;
        end
    end

    // Tag store: block start and use stamp per slot.
    lrbc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_sel),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_entry)
    );

    // Shared compare unit.
    lrbc_scan #(
        .SLOT_W (SLOT_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_idx        (w_proc_idx),
        .i_entry      (w_rd_entry),
        .i_blk        (r_blk),
        .o_flags      (w_flags),
        .o_hit_idx    (w_hit_idx),
        .o_empty_idx  (w_empty_idx),
        .o_best_idx   (w_best_idx),
        .o_best_start (w_best_start)
    );

`ifndef NO_ASSERTIONS
    // The use counter never passes its saturation value.
    a_use_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_use_cnt <= STAMP_MAX)
        else $error("use counter above saturation value");

    // The current slot always holds a valid block.
    a_cur_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_valid[r_cur_idx])
        else $error("current slot is not valid");

    // A pending result never reports both a hit and a fill.
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.hit && r_out.need_fill))
        else $error("result reports hit and fill together");

    // An eviction is always part of a fill.
    a_evict_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.evicted_valid) |-> r_out.need_fill)
        else $error("eviction without fill");

    // A finished scan has stepped through exactly the active slots.
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (n_state == ST_UPDATE)) |=> (r_idx == r_n))
        else $error("scan ended at the wrong slot count");
`endif

endmodule

`default_nettype wire
